### hw/rtl/bbcc_pkg.sv
`timescale 1ns / 1ps
package bbcc_pkg;
  localparam int unsigned DefaultEntries = 16;
  localparam int unsigned ResultLimit = 16;

  typedef enum logic [2:0] {
    OpGet = 3'd0,
    OpRelease = 3'd1,
    OpMarkDirty = 3'd2,
    OpFlush = 3'd3,
    OpFillFailed = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KindGrant = 2'd0,
    KindWrite = 2'd1,
    KindRead = 2'd2,
    KindDone = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    StIdle,
    StHitScan,
    StFreeScan,
    StMissEmit,
    StFlushScan,
    StEmit,
    StSingle
  } state_e;
endpackage

### hw/rtl/block_buffer_cache_controller_top.sv
`timescale 1ns / 1ps
// A get walks both memories one slot a cycle, first for a hit and then for a free slot;
// a flush walks them for dirty slots. One item is in work at a time, and the next is
// taken only after the last result of the one before; output stalls hold the flow.
// Reset clears control state and the valid and dirty flags; counts read as zero while invalid.
module block_buffer_cache_controller_top
  import bbcc_pkg::*;
#(
  parameter int unsigned Entries = DefaultEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // Fields from bit 0: operation[2:0], block_number[34:3], slot[38:35], zero fill.
  input  logic [39:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // Fields from bit 0: result_slot[3:0], result_block[35:4].
  output logic [39:0] m_axis_tdata_o,
  // Field: kind[1:0].
  output logic [1:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);
  localparam int unsigned Aw = $clog2(Entries);
  localparam int unsigned Cw = $clog2(Entries + 1);

  // The victim register reduced modulo Entries, one entry per register value.
  function automatic logic [16*Aw-1:0] victim_map();
    logic [16*Aw-1:0] m;
    m = '0;
    for (int v = 0; v < 16; v++) m[v*Aw +: Aw] = Aw'(32'(v) % Entries);
    return m;
  endfunction
  localparam logic [16*Aw-1:0] VictimMap = victim_map();

  // Valid and dirty flags are flip-flops with reset; tags and counts live in RAMs.
  // A count is only trusted while its slot is valid, so the count RAM needs no clearing.
  logic [Entries-1:0] valid_q, dirty_q;
  logic [3:0] victim_q;

  state_e state_q, state_d;
  logic [2:0]  op_q;
  logic [31:0] blk_q;
  logic [3:0]  slot_q;
  logic [Cw-1:0] idx_q, idx_d;
  logic [Aw-1:0] pick_q;
  logic        found_q;
  logic [4:0]  nwb_q;
  logic [1:0]  step_q;

  // Output register.
  logic        ov_q;
  logic [1:0]  okind_q;
  logic [3:0]  oslot_q;
  logic [31:0] oblk_q;
  logic        olast_q;

  logic          ram_we;
  logic [Aw-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_rdata;
  logic [Aw-1:0] rd_slot_q;

  // Both memories share the read address. Every count write lands before the next
  // item is taken, so a read never overlaps a pending write to the same slot.
  logic          cnt_we;
  logic [Aw-1:0] cnt_waddr;
  logic [7:0]    cnt_wdata;
  logic [7:0]    cnt_rdata;

  bbcc_ram #(.Width(32), .Depth(Entries)) u_tag (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(blk_q),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  bbcc_ram #(.Width(8), .Depth(Entries)) u_cnt (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(cnt_wdata),
    .raddr_i(ram_raddr), .rdata_o(cnt_rdata)
  );

  wire [2:0]  in_op   = s_axis_tdata_i[2:0];
  wire [31:0] in_blk  = s_axis_tdata_i[34:3];
  wire [3:0]  in_slot = s_axis_tdata_i[38:35];
  wire in_acc = s_axis_tvalid_i && s_axis_tready_o;
  wire out_free = !ov_q || m_axis_tready_i;

  assign s_axis_tready_o = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tuser_o = okind_q;
  assign m_axis_tlast_o = olast_q;
  assign m_axis_tdata_o = {4'd0, oblk_q, oslot_q};

  wire idx_in = (idx_q < Cw'(Entries));
  wire [Aw-1:0] idx_a = idx_in ? idx_q[Aw-1:0] : '0;
  // Data read last cycle belongs to rd_slot_q.
  wire rd_hit = valid_q[rd_slot_q] && (ram_rdata == blk_q);
  wire [7:0] cnt_cur = valid_q[rd_slot_q] ? cnt_rdata : 8'd0;
  wire free_now = (idx_q != '0) && (cnt_cur == 8'd0);
  wire slot_ok = (32'(slot_q) < Entries);
  wire [Aw-1:0] slot_a = Aw'(slot_q);
  wire [Aw-1:0] victim_a = VictimMap[32'(victim_q) * Aw +: Aw];

  logic emit;
  logic [1:0] ekind;
  logic [3:0] eslot;
  logic [31:0] eblk;
  logic elast;

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    ram_raddr = idx_a;
    ram_we = 1'b0;
    ram_waddr = pick_q;
    cnt_we = 1'b0;
    cnt_waddr = pick_q;
    cnt_wdata = 8'd1;
    emit = 1'b0;
    ekind = KindDone;
    eslot = slot_q;
    eblk = '0;
    elast = 1'b1;
    unique case (state_q)
      StIdle: begin
        // A single-slot item finds the count of its slot ready in the next cycle.
        ram_raddr = Aw'(in_slot);
        if (in_acc) begin
          idx_d = '0;
          priority case (in_op)
            OpGet: state_d = StHitScan;
            OpFlush: state_d = StFlushScan;
            default: state_d = StSingle;
          endcase
        end
      end
      StHitScan: begin
        // idx_q is the address being read; rd_slot_q's data is valid once idx_q>0.
        if (idx_q != '0 && rd_hit) begin
          // Keep the matching slot addressed while the output is busy.
          ram_raddr = rd_slot_q;
          if (out_free) begin
            emit = 1'b1;
            ekind = KindGrant;
            eslot = 4'(rd_slot_q);
            eblk = blk_q;
            cnt_we = (cnt_cur != 8'hff);
            cnt_waddr = rd_slot_q;
            cnt_wdata = cnt_cur + 8'd1;
            state_d = StIdle;
          end
        end else if (idx_q == Cw'(Entries)) begin
          state_d = StFreeScan;
          idx_d = '0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StFreeScan: begin
        // Counts are read one slot per cycle; the first zero count wins.
        if (idx_q == Cw'(Entries)) begin
          // Address the chosen slot so its old tag is ready for the write-back.
          if (found_q) begin
            ram_raddr = pick_q;
          end else if (free_now) begin
            ram_raddr = rd_slot_q;
          end else begin
            ram_raddr = victim_a;
          end
          state_d = StMissEmit;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StMissEmit: begin
        ram_raddr = pick_q;
        if (out_free) begin
          emit = 1'b1;
          eslot = 4'(pick_q);
          elast = 1'b0;
          if (step_q == 2'd0 && valid_q[pick_q] && dirty_q[pick_q]) begin
            ekind = KindWrite;
            eblk = ram_rdata;
          end else if (step_q != 2'd2) begin
            ekind = KindRead;
            eblk = blk_q;
          end else begin
            ekind = KindGrant;
            eblk = blk_q;
            elast = 1'b1;
            ram_we = 1'b1;
            cnt_we = 1'b1;
            state_d = StIdle;
          end
        end
      end
      StFlushScan: begin
        // Address idx_q read now; data for rd_slot_q checked when idx_q>0.
        if (idx_q != '0 && valid_q[rd_slot_q] && dirty_q[rd_slot_q]
            && nwb_q < 5'(ResultLimit)) begin
          // Hold the dirty slot addressed so its tag is read for the write-back.
          ram_raddr = rd_slot_q;
          state_d = StEmit;
        end else if (idx_q == Cw'(Entries) || !idx_in) begin
          if (out_free) begin
            if (nwb_q == '0) begin
              emit = 1'b1;
              eslot = '0;
              state_d = StIdle;
            end else begin
              // Final write-back waits in the hold register and is loaded into the
              // output register now, with last set.
              state_d = StIdle;
            end
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StEmit: begin
        ram_raddr = rd_slot_q;
        if (out_free) begin
          emit = 1'b1;
          ekind = KindWrite;
          eslot = 4'(rd_slot_q);
          eblk = ram_rdata;
          elast = 1'b0;
          state_d = StFlushScan;
          idx_d = Cw'(rd_slot_q) + 1'b1;
        end
      end
      StSingle: begin
        ram_raddr = slot_a;
        if (out_free) begin
          emit = 1'b1;
          state_d = StIdle;
          cnt_waddr = slot_a;
          if (slot_ok && op_q == OpRelease && cnt_cur != 8'd0) begin
            cnt_we = 1'b1;
            cnt_wdata = cnt_cur - 8'd1;
          end else if (slot_ok && op_q == OpFillFailed) begin
            cnt_we = 1'b1;
            cnt_wdata = 8'd0;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // A flush holds its newest write-back until it knows whether another follows,
  // so last can be set on the real final one.
  logic        hold_q;
  logic [3:0]  hslot_q;
  logic [31:0] hblk_q;
  logic        ov_set;

  assign ov_set = (emit && (state_q != StEmit || hold_q))
               || (state_q == StFlushScan && state_d == StIdle && nwb_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= '0;
      dirty_q <= '0;
      victim_q <= '0;
      ov_q <= 1'b0;
      hold_q <= 1'b0;
      idx_q <= '0;
      found_q <= 1'b0;
      pick_q <= '0;
      nwb_q <= '0;
      step_q <= '0;
      rd_slot_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      rd_slot_q <= ram_raddr;
      if (cfg_valid_i) victim_q <= cfg_data_i;
      if (ov_set) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ov_q <= 1'b0;
      end
      if (in_acc) begin
        op_q <= in_op;
        blk_q <= in_blk;
        slot_q <= in_slot;
        found_q <= 1'b0;
        nwb_q <= '0;
        step_q <= '0;
        hold_q <= 1'b0;
      end
      if (state_q == StFreeScan && !found_q) begin
        if (free_now) begin
          found_q <= 1'b1;
          pick_q <= rd_slot_q;
        end else if (idx_q == Cw'(Entries)) begin
          pick_q <= victim_a;
        end
      end
      if (state_q == StFlushScan && state_d == StIdle && nwb_q != '0) begin
        okind_q <= KindWrite;
        oslot_q <= hslot_q;
        oblk_q <= hblk_q;
        olast_q <= 1'b1;
        hold_q <= 1'b0;
      end
      if (emit) begin
        if (state_q == StEmit) begin
          if (hold_q) begin
            okind_q <= KindWrite;
            oslot_q <= hslot_q;
            oblk_q <= hblk_q;
            olast_q <= 1'b0;
          end
          hold_q <= 1'b1;
          hslot_q <= eslot;
          hblk_q <= eblk;
          nwb_q <= nwb_q + 1'b1;
          dirty_q[rd_slot_q] <= 1'b0;
        end else begin
          okind_q <= ekind;
          oslot_q <= eslot;
          oblk_q <= eblk;
          olast_q <= elast;
        end
        if (state_q == StMissEmit) begin
          step_q <= (ekind == KindWrite) ? 2'd1 : 2'd2;
          if (ekind == KindGrant) begin
            valid_q[pick_q] <= 1'b1;
            dirty_q[pick_q] <= 1'b0;
          end
        end
        if (state_q == StSingle && slot_ok) begin
          unique case (op_q)
            OpMarkDirty: dirty_q[slot_a] <= 1'b1;
            OpFillFailed: begin
              valid_q[slot_a] <= 1'b0;
              dirty_q[slot_a] <= 1'b0;
            end
            default: ;
          endcase
        end
      end
    end
  end
endmodule

### hw/rtl/bbcc_ram.sv
`timescale 1ns / 1ps
module bbcc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### test/tb_block_buffer_cache_controller_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the buffer cache controller. A driver feeds requests
// from a queue, a shadow copy of the tag table predicts every result, and a
// monitor compares the output stream item by item.
module tb_block_buffer_cache_controller_top
  import bbcc_pkg::*;
();

  localparam int unsigned NumSlots = 16;
  localparam int unsigned IdleWait = 2 * NumSlots + 8;
  localparam int unsigned CycleLimit = 1000000;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] blk;
    logic [3:0]  slot;
  } req_t;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  slot;
    logic [31:0] blk;
    logic        last;
  } resp_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [39:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  block_buffer_cache_controller_top #(.Entries(NumSlots)) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o),
    .m_axis_tuser_o(m_axis_tuser_o),
    .m_axis_tlast_o(m_axis_tlast_o)
  );

  // Shadow of the cache state.
  logic [31:0] shadow_tag [NumSlots];
  bit          shadow_valid [NumSlots];
  bit          shadow_dirty [NumSlots];
  logic [7:0]  shadow_refs [NumSlots];
  logic [3:0]  shadow_victim;

  req_t  request_q[$];
  resp_t expected_q[$];
  int    error_count;
  int    cycle_count;
  bit    in_fire;
  int    send_gap;
  int    send_burst;
  int    recv_gap;
  int    recv_burst;
  int    hold_left;
  bit    hold_req;
  bit    hold_done;
  logic [31:0] block_pool [24];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic push_result(kind_e k, logic [3:0] s, logic [31:0] b, logic l);
    resp_t r;
    r.kind = k;
    r.slot = s;
    r.blk = b;
    r.last = l;
    expected_q.push_back(r);
  endtask

  task automatic predict_cache(req_t rq);
    int pick;
    int writes;
    pick = -1;
    writes = 0;
    case (rq.op)
      OpGet: begin
        for (int i = 0; i < NumSlots; i++) begin
          if (pick < 0 && shadow_valid[i] && shadow_tag[i] == rq.blk) pick = i;
        end
        if (pick >= 0) begin
          if (shadow_refs[pick] != 8'd255) shadow_refs[pick]++;
          push_result(KindGrant, pick[3:0], rq.blk, 1'b1);
        end else begin
          for (int i = 0; i < NumSlots; i++) begin
            if (pick < 0 && shadow_refs[i] == 8'd0) pick = i;
          end
          if (pick < 0) pick = shadow_victim % NumSlots;
          if (shadow_valid[pick] && shadow_dirty[pick])
            push_result(KindWrite, pick[3:0], shadow_tag[pick], 1'b0);
          push_result(KindRead, pick[3:0], rq.blk, 1'b0);
          push_result(KindGrant, pick[3:0], rq.blk, 1'b1);
          shadow_tag[pick] = rq.blk;
          shadow_valid[pick] = 1'b1;
          shadow_dirty[pick] = 1'b0;
          shadow_refs[pick] = 8'd1;
        end
      end
      OpFlush: begin
        for (int i = 0; i < NumSlots; i++) begin
          if (shadow_valid[i] && shadow_dirty[i] && writes < ResultLimit) begin
            push_result(KindWrite, i[3:0], shadow_tag[i], 1'b0);
            shadow_dirty[i] = 1'b0;
            writes++;
          end
        end
        if (writes == 0) push_result(KindDone, 4'd0, 32'd0, 1'b1);
        else expected_q[$].last = 1'b1;
      end
      OpRelease: begin
        if (shadow_refs[rq.slot] != 8'd0) shadow_refs[rq.slot]--;
        push_result(KindDone, rq.slot, 32'd0, 1'b1);
      end
      OpMarkDirty: begin
        shadow_dirty[rq.slot] = 1'b1;
        push_result(KindDone, rq.slot, 32'd0, 1'b1);
      end
      OpFillFailed: begin
        shadow_valid[rq.slot] = 1'b0;
        shadow_dirty[rq.slot] = 1'b0;
        shadow_refs[rq.slot] = 8'd0;
        push_result(KindDone, rq.slot, 32'd0, 1'b1);
      end
      default: push_result(KindDone, rq.slot, 32'd0, 1'b1);
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Input side: predict on every accepted request.
  always @(posedge clk_i) begin
    in_fire <= s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      predict_cache(req_t'({s_axis_tdata_i[2:0], s_axis_tdata_i[34:3], s_axis_tdata_i[38:35]}));
    if (rst_ni && cfg_valid_i && cfg_ready_o) shadow_victim = cfg_data_i;
  end

  // Driver: holds an item until it is taken, then maybe idles.
  always @(negedge clk_i) begin
    req_t nx;
    if (rst_ni) begin
      if (!s_axis_tvalid_i || in_fire) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid_i <= 1'b0;
        end else if (request_q.size() > 0) begin
          nx = request_q.pop_front();
          s_axis_tdata_i <= {1'b0, nx.slot, nx.blk, nx.op};
          s_axis_tvalid_i <= 1'b1;
          if (send_burst > 0) begin
            send_burst <= send_burst - 1;
            send_gap <= 0;
          end else if ($urandom_range(0, 49) == 0) begin
            send_burst <= 30;
            send_gap <= 0;
          end else begin
            send_gap <= pick_gap();
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready_i <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= 600;
        m_axis_tready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (recv_burst > 0) recv_burst <= recv_burst - 1;
        else if ($urandom_range(0, 79) == 0) recv_burst <= 60;
        else recv_gap <= pick_gap();
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    resp_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result slot=%0d block=%h kind=%0d last=%b", $time,
                 m_axis_tdata_o[3:0], m_axis_tdata_o[35:4], m_axis_tuser_o, m_axis_tlast_o);
        error_count++;
      end else begin
        exp_r = expected_q.pop_front();
        if (m_axis_tuser_o != exp_r.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, exp_r.kind, m_axis_tuser_o);
          error_count++;
        end
        if (m_axis_tdata_o[3:0] != exp_r.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, exp_r.slot,
                   m_axis_tdata_o[3:0]);
          error_count++;
        end
        if (m_axis_tdata_o[35:4] != exp_r.blk) begin
          $display("%0t: block expected %h actual %h", $time, exp_r.blk,
                   m_axis_tdata_o[35:4]);
          error_count++;
        end
        if (m_axis_tlast_o != exp_r.last) begin
          $display("%0t: last expected %b actual %b", $time, exp_r.last, m_axis_tlast_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_block_buffer_cache_controller_top: errors");
      $finish;
    end
  end

  task automatic add_req(logic [2:0] op, logic [31:0] blk, logic [3:0] slot);
    req_t rq;
    rq.op = op;
    rq.blk = blk;
    rq.slot = slot;
    request_q.push_back(rq);
  endtask

  task automatic wait_drained();
    while (request_q.size() > 0 || s_axis_tvalid_i || expected_q.size() > 0)
      @(posedge clk_i);
    repeat (IdleWait) @(posedge clk_i);
  endtask

  task automatic write_victim(logic [3:0] value);
    @(negedge clk_i);
    cfg_data_i = value;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic add_random(int count);
    int r;
    logic [31:0] b;
    logic [3:0] s;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      b = ($urandom_range(0, 9) == 0) ? $urandom() : block_pool[$urandom_range(0, 23)];
      s = 4'($urandom_range(0, 15));
      if (r < 45) add_req(OpGet, b, s);
      else if (r < 63) add_req(OpRelease, $urandom(), s);
      else if (r < 79) add_req(OpMarkDirty, $urandom(), s);
      else if (r < 88) add_req(OpFlush, $urandom(), s);
      else if (r < 95) add_req(OpFillFailed, $urandom(), s);
      else add_req(3'($urandom_range(5, 7)), $urandom(), s);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    error_count = 0;
    cycle_count = 0;
    send_gap = 0;
    send_burst = 0;
    recv_gap = 0;
    recv_burst = 0;
    hold_left = 0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    shadow_victim = '0;
    for (int i = 0; i < NumSlots; i++) begin
      shadow_tag[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_dirty[i] = 1'b0;
      shadow_refs[i] = '0;
    end
    block_pool[0] = 32'd0;
    block_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 24; i++) block_pool[i] = $urandom();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, hits, misses over a dirty slot, flushes, odd slots.
    write_victim(4'd0);
    add_req(OpFlush, 32'd0, 4'd9);
    add_req(OpGet, 32'd0, 4'd0);
    add_req(OpGet, 32'hFFFF_FFFF, 4'd15);
    add_req(OpGet, 32'd0, 4'd0);
    add_req(OpMarkDirty, 32'hFFFF_FFFF, 4'd0);
    add_req(OpMarkDirty, 32'd0, 4'd15);
    add_req(OpRelease, 32'd0, 4'd15);
    add_req(OpRelease, 32'd0, 4'd15);
    add_req(OpMarkDirty, 32'd0, 4'd1);
    add_req(OpGet, 32'h1234_5678, 4'd0);
    add_req(OpFlush, 32'hFFFF_FFFF, 4'd15);
    add_req(OpFlush, 32'd0, 4'd0);
    add_req(OpRelease, 32'd0, 4'd0);
    add_req(OpRelease, 32'd0, 4'd0);
    add_req(OpRelease, 32'd0, 4'd0);
    add_req(OpMarkDirty, 32'd0, 4'd0);
    add_req(OpGet, 32'hA5A5_5A5A, 4'd0);
    add_req(OpFillFailed, 32'd0, 4'd0);
    add_req(OpFillFailed, 32'd0, 4'd15);
    add_req(3'd5, 32'hFFFF_FFFF, 4'd15);
    add_req(3'd6, 32'd0, 4'd3);
    add_req(3'd7, 32'h8000_0001, 4'd10);
    wait_drained();

    // Victim at the top slot: many gets with few releases fill every slot.
    write_victim(4'd15);
    for (int i = 0; i < 18; i++) add_req(OpGet, block_pool[i], 4'd0);
    add_random(20);
    wait_drained();

    // Long receiver hold-off, count saturation, random victim.
    write_victim(4'($urandom_range(1, 14)));
    hold_req = 1'b1;
    for (int i = 0; i < 258; i++) add_req(OpGet, 32'h0000_0777, 4'd0);
    add_random(10);
    wait_drained();

    write_victim(4'd0);
    add_random(4);
    wait_drained();

    if (error_count == 0) begin
      $display("tb_block_buffer_cache_controller_top: clean");
    end else begin
      $display("tb_block_buffer_cache_controller_top: errors");
    end
    $finish;
  end
endmodule
